[hdl/prp_pkg.sv]
// Shared types and constants for the page replacement policy block.
// No dependencies; the top level, the sequencer and the checker import this package.
package prp_pkg;

	localparam int POLICY_W  = 3;
	localparam int FRAMES_W  = 5;
	localparam int TOTAL_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = CFG_IDX_W'(1);

	localparam logic [POLICY_W-1:0] POL_FIFO     = 3'd0;
	localparam logic [POLICY_W-1:0] POL_LRU      = 3'd1;
	localparam logic [POLICY_W-1:0] POL_LFU_FIFO = 3'd2;
	localparam logic [POLICY_W-1:0] POL_LFU_LRU  = 3'd3;
	localparam logic [POLICY_W-1:0] POL_MFU_FIFO = 3'd4;
	localparam logic [POLICY_W-1:0] POL_MFU_LRU  = 3'd5;

	localparam logic [POLICY_W-1:0] POLICY_RST = POL_FIFO;
	localparam logic [FRAMES_W-1:0] FRAMES_RST = 5'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic fault;
		logic replaced;
	} res_flags_t;

endpackage

[hdl/page_replacement_policy_top.sv]
// Top level of the page replacement policy block: configuration registers,
// result register, frame table memory and sequencer. Uses prp_pkg.
//
// The frame table is one memory with a single read port, so the lookup reads
// every occupied entry once; when the table is empty the lookup is skipped.
// A move to the youngest place or an eviction then copies each younger entry
// one place down, one entry per cycle. The next reference is taken while a
// result still waits in the output register.
// Configuration writes are always taken; change them only while idle.
module page_replacement_policy_top
	import prp_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [CFG_IDX_W-1:0]             cfg_index,
	input  logic [CFG_DAT_W-1:0]             cfg_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [PAGE_BITS-1:0]             page,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic                             fault,
	output logic                             replaced,
	output logic [PAGE_BITS-1:0]             evicted_page,
	output logic [$clog2(MAX_FRAMES+1)-1:0]  resident_count,
	output logic [TOTAL_W-1:0]               fault_count,
	output logic [TOTAL_W-1:0]               replace_count
);

	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int OW = $clog2(MAX_FRAMES + 1);
	localparam int MW = PAGE_BITS + COUNT_BITS;

	logic [POLICY_W-1:0]  policy_q;
	logic [FRAMES_W-1:0]  frames_q;

	logic                 res_valid, res_ready;
	res_flags_t           res_flags;
	logic [PAGE_BITS-1:0] res_evicted;
	logic [OW-1:0]        res_occ;
	logic [TOTAL_W-1:0]   res_faults, res_replaces;

	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [MW-1:0]        mem_wdata, mem_rdata;

	logic                 rsp_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_RST;
			frames_q <= FRAMES_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[POLICY_W-1:0];
				REG_FRAMES: frames_q <= cfg_data[FRAMES_W-1:0];
				default:    ;
			endcase
		end
	end

	prp_frame_mem #(
		.DEPTH (MAX_FRAMES),
		.WIDTH (MW),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	prp_ctrl #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW),
		.OW         (OW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.page         (page),
		.policy       (policy_q),
		.frames       (frames_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_flags    (res_flags),
		.res_evicted  (res_evicted),
		.res_occ      (res_occ),
		.res_faults   (res_faults),
		.res_replaces (res_replaces),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	// Output register: load when empty or being drained.
	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			fault          <= res_flags.fault;
			replaced       <= res_flags.replaced;
			evicted_page   <= res_evicted;
			resident_count <= res_occ;
			fault_count    <= res_faults;
			replace_count  <= res_replaces;
		end
	end

endmodule

[hdl/prp_frame_mem.sv]
// Frame table storage: one write port, one read port, registered read data.
// Each word holds a page id above its use count. Depends on nothing.
module prp_frame_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 24,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/prp_ctrl.sv]
// Reference sequencer: scans the frame table, picks the victim, compacts the
// table and updates the totals. Uses prp_pkg and drives prp_frame_mem ports.
module prp_ctrl
	import prp_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 8,
	parameter int COUNT_BITS = 16,
	parameter int AW         = 4,
	parameter int OW         = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [PAGE_BITS-1:0]          page,
	input  logic [POLICY_W-1:0]           policy,
	input  logic [FRAMES_W-1:0]           frames,
	output logic                          res_valid,
	input  logic                          res_ready,
	output res_flags_t                    res_flags,
	output logic [PAGE_BITS-1:0]          res_evicted,
	output logic [OW-1:0]                 res_occ,
	output logic [TOTAL_W-1:0]            res_faults,
	output logic [TOTAL_W-1:0]            res_replaces,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [PAGE_BITS+COUNT_BITS-1:0] mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [PAGE_BITS+COUNT_BITS-1:0] mem_rdata
);

	localparam int LW = (OW > FRAMES_W) ? OW : FRAMES_W;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	state_t state_q, state_d;

	logic [PAGE_BITS-1:0]  page_q;
	logic                  lru_q, lfu_q, mfu_q;
	logic [LW-1:0]         limit_q;
	logic [OW-1:0]         occ_q;
	logic [OW-1:0]         ptr_q;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic                  hit_q;
	logic [AW-1:0]         hit_idx_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic [AW-1:0]         vic_idx_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [PAGE_BITS-1:0]  vic_page_q;
	logic [COUNT_BITS-1:0] fin_cnt_q;
	logic                  fault_q, replaced_q;
	logic [PAGE_BITS-1:0]  evict_q;
	logic [TOTAL_W-1:0]    faults_q, replaces_q;

	logic                  lru_c, lfu_c, mfu_c;
	logic [LW-1:0]         limit_c;
	logic [PAGE_BITS-1:0]  rd_page;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] hit_inc;
	logic                  sweep_done;
	logic                  evict_c;
	logic                  accept;

	assign rd_page    = mem_rdata[PAGE_BITS+COUNT_BITS-1:COUNT_BITS];
	assign rd_cnt     = mem_rdata[COUNT_BITS-1:0];
	assign hit_inc    = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CNT_ONE;
	assign sweep_done = (ptr_q == occ_q) && !rd_vld_s1;
	assign evict_c    = !hit_q && (LW'(occ_q) >= limit_q) && (occ_q != '0);
	assign accept     = req_valid && req_ready;

	// Policy decode; unused codes act as plain fifo.
	always_comb begin
		lru_c = 1'b0;
		lfu_c = 1'b0;
		mfu_c = 1'b0;
		unique case (policy)
			POL_LRU:      lru_c = 1'b1;
			POL_LFU_FIFO: lfu_c = 1'b1;
			POL_LFU_LRU:  begin lfu_c = 1'b1; lru_c = 1'b1; end
			POL_MFU_FIFO: mfu_c = 1'b1;
			POL_MFU_LRU:  begin mfu_c = 1'b1; lru_c = 1'b1; end
			default:      ;
		endcase
	end

	// Clamp the frame limit into 1..MAX_FRAMES.
	always_comb begin
		if (frames == '0) begin
			limit_c = LW'(1);
		end else if (LW'(frames) > LW'(MAX_FRAMES)) begin
			limit_c = LW'(MAX_FRAMES);
		end else begin
			limit_c = LW'(frames);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req_valid) state_d = (occ_q == '0) ? ST_DECIDE : ST_SCAN;
			ST_SCAN:   if (sweep_done) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ((hit_q && lru_q) || evict_c) ? ST_SHIFT : ST_DONE;
			ST_SHIFT:  if (sweep_done) state_d = ST_DONE;
			ST_DONE:   if (res_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		mem_re    = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (ptr_q < occ_q);
		mem_raddr = ptr_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (state_q)
			ST_DECIDE: begin
				if (hit_q && !lru_q) begin
					mem_we    = 1'b1;
					mem_waddr = hit_idx_q;
					mem_wdata = {page_q, hit_inc};
				end else if (!hit_q && !evict_c) begin
					mem_we    = 1'b1;
					mem_waddr = occ_q[AW-1:0];
					mem_wdata = {page_q, CNT_ONE};
				end
			end
			ST_SHIFT: begin
				if (rd_vld_s1) begin
					// move the younger entry one place toward the old end
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - AW'(1);
					mem_wdata = mem_rdata;
				end else if (ptr_q == occ_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(occ_q - OW'(1));
					mem_wdata = {page_q, fin_cnt_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			occ_q      <= '0;
			ptr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			faults_q   <= '0;
			replaces_q <= '0;
			fault_q    <= 1'b0;
			replaced_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			if (mem_re) begin
				ptr_q <= ptr_q + OW'(1);
			end
			if (accept) begin
				hit_q <= 1'b0;
				ptr_q <= '0;
			end
			if ((state_q == ST_SCAN) && rd_vld_s1 && !hit_q && (rd_page == page_q)) begin
				hit_q <= 1'b1;
			end
			if (state_q == ST_DECIDE) begin
				fault_q    <= !hit_q;
				replaced_q <= evict_c;
				ptr_q      <= OW'(hit_q ? hit_idx_q : vic_idx_q) + OW'(1);
				if (!hit_q && (faults_q != '1)) begin
					faults_q <= faults_q + TOTAL_W'(1);
				end
				if (evict_c && (replaces_q != '1)) begin
					replaces_q <= replaces_q + TOTAL_W'(1);
				end
				if (!hit_q && !evict_c) begin
					occ_q <= occ_q + OW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= mem_raddr;
		if (accept) begin
			page_q  <= page;
			lru_q   <= lru_c;
			lfu_q   <= lfu_c;
			mfu_q   <= mfu_c;
			limit_q <= limit_c;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (!hit_q && (rd_page == page_q)) begin
				hit_idx_q <= rd_idx_s1;
				hit_cnt_q <= rd_cnt;
			end
			// strict compare keeps the oldest entry on ties
			if ((rd_idx_s1 == '0) || (lfu_q && (rd_cnt < vic_cnt_q))
					|| (mfu_q && (rd_cnt > vic_cnt_q))) begin
				vic_idx_q  <= rd_idx_s1;
				vic_cnt_q  <= rd_cnt;
				vic_page_q <= rd_page;
			end
		end
		if (state_q == ST_DECIDE) begin
			fin_cnt_q <= hit_q ? hit_inc : CNT_ONE;
			evict_q   <= evict_c ? vic_page_q : '0;
		end
	end

	assign res_flags    = '{fault: fault_q, replaced: replaced_q};
	assign res_evicted  = evict_q;
	assign res_occ      = occ_q;
	assign res_faults   = faults_q;
	assign res_replaces = replaces_q;

endmodule

[hdl/prp_checker.sv]
// Port-level checks for page_replacement_policy_top, bound to every instance.
// Uses prp_pkg for the fixed field widths.
module prp_checker
	import prp_pkg::*;
#(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS  = 8
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic                            fault,
	input logic                            replaced,
	input logic [PAGE_BITS-1:0]            evicted_page,
	input logic [$clog2(MAX_FRAMES+1)-1:0] resident_count,
	input logic [TOTAL_W-1:0]              fault_count,
	input logic [TOTAL_W-1:0]              replace_count
);

	// an eviction only happens on a fault, and reports no page otherwise
	a_replace_needs_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (fault || !replaced))
		else $error("replacement without a fault");

	a_no_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !replaced) |-> (evicted_page == '0))
		else $error("evicted page set without a replacement");

	a_occupancy_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((resident_count != '0) && (resident_count <= MAX_FRAMES)))
		else $error("resident count out of range");

	a_totals_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (replace_count <= fault_count))
		else $error("replacement total above fault total");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(fault_count)))
		else $error("stalled result changed");

endmodule

bind page_replacement_policy_top prp_checker #(
	.MAX_FRAMES (MAX_FRAMES),
	.PAGE_BITS  (PAGE_BITS)
) u_prp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp_valid),
	.rsp_ready      (rsp_ready),
	.fault          (fault),
	.replaced       (replaced),
	.evicted_page   (evicted_page),
	.resident_count (resident_count),
	.fault_count    (fault_count),
	.replace_count  (replace_count)
);
